// ===== sv/indexed_sequence_store_macros.svh =====
// assertion macros for the indexed sequence store
// included in the top level, expects i_clk and i_rst_n in scope
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed sequence store check failed");

// next-cycle implication, checked outside reset
`define ISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed sequence store check failed");

`endif

// ===== sv/iss_pkg.sv =====
// shared types and constants for the indexed sequence store
// no dependencies; used by iss_cell and indexed_sequence_store
package iss_pkg;

    // field widths of the command and result
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 5;
    localparam int CNT_W  = 6;

    // default number of cells
    localparam int ISS_DEPTH = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;   // shift up from the insert point, load the new value there
        logic del;   // shift down from the delete point
        logic find;  // capture value match
        logic rd;    // capture position match
    } t_cell_ctrl;

endpackage

// ===== sv/iss_cell.sv =====
// one storage cell of the sequence chain: holds one entry and a match flag
// depends on iss_pkg; instantiated in a row by indexed_sequence_store
module iss_cell #(
    parameter int IDX = 0,
    parameter int CW  = iss_pkg::POS_W
) (
    input  logic                           i_clk,
    input  iss_pkg::t_cell_ctrl            i_ctrl,
    input  logic [CW-1:0]                  i_ins_pos,
    input  logic [CW-1:0]                  i_pos,
    input  logic [CW-1:0]                  i_held,
    input  logic signed [iss_pkg::VAL_W-1:0] i_value,
    input  logic signed [iss_pkg::VAL_W-1:0] i_left,
    input  logic signed [iss_pkg::VAL_W-1:0] i_right,
    output logic signed [iss_pkg::VAL_W-1:0] o_entry,
    output logic                           o_hit
);
    import iss_pkg::*;

    localparam logic [CW-1:0] K  = CW'(IDX);
    localparam logic [CW-1:0] K1 = CW'(IDX + 1);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    r_hit;
    logic                    n_hit;

    // entry update: take the left neighbor, the right neighbor or the new value
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (K == i_ins_pos) begin
                n_entry = i_value;
            end else if (K > i_ins_pos && K <= i_held) begin
                n_entry = i_left;
            end
        end else if (i_ctrl.del) begin
            if (K >= i_pos && K1 < i_held) begin
                n_entry = i_right;
            end
        end
    end

    // match flag for read and search
    always_comb begin
        n_hit = r_hit;
        if (i_ctrl.find) begin
            n_hit = (K < i_held) && (r_entry == i_value);
        end else if (i_ctrl.rd) begin
            n_hit = (K == i_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== sv/indexed_sequence_store.sv =====
// top level of the indexed sequence store: row of cells, decode and result scan
// depends on iss_pkg, iss_cell and indexed_sequence_store_macros.svh
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  command  | start in, busy out       | i_cmd, i_position, i_value
//  result   | o_done out (one cycle)   | o_status, o_read_value, o_found_position,
//           |                          | o_count
//
// insert, delete, clear and rejected commands: result strobed on the next cycle
// read in range and search: cells latch match flags, then in the scan state a priority
// scan over the match row picks position and data and registers the result; busy is
// high in the scan state. synchronous active-low reset clears the count and the
// controller; cell contents are undefined until written. results cannot be stalled
module indexed_sequence_store #(
    parameter int DEPTH = iss_pkg::ISS_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [iss_pkg::CMD_W-1:0]           i_cmd,
    input  logic [iss_pkg::POS_W-1:0]           i_position,
    input  logic signed [iss_pkg::VAL_W-1:0]    i_value,
    output logic                                o_done,
    output logic [iss_pkg::ST_W-1:0]            o_status,
    output logic signed [iss_pkg::VAL_W-1:0]    o_read_value,
    output logic [iss_pkg::FPOS_W-1:0]          o_found_position,
    output logic [iss_pkg::CNT_W-1:0]           o_count
);
    import iss_pkg::*;
    `include "indexed_sequence_store_macros.svh"

    localparam int HW = $clog2(DEPTH + 1);
    localparam int CW = (HW > POS_W) ? HW : POS_W;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_held;
    logic [CW-1:0]           n_held;
    logic                    r_is_read;
    logic                    n_is_read;
    logic                    r_done;
    logic                    n_done;
    logic [ST_W-1:0]         r_status;
    logic [ST_W-1:0]         n_status;
    logic signed [VAL_W-1:0] r_rd;
    logic signed [VAL_W-1:0] n_rd;
    logic [FPOS_W-1:0]       r_fpos;
    logic [FPOS_W-1:0]       n_fpos;

    logic                    w_accept;
    logic [CW-1:0]           w_pos;
    logic [CW-1:0]           w_ins_pos;
    logic                    w_full;
    t_cell_ctrl              w_ctrl;

    logic signed [VAL_W-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]        w_hit;
    logic [DEPTH-1:0]        w_first;
    logic [PW-1:0]           w_idx;
    logic signed [VAL_W-1:0] w_data;

    assign busy     = (r_state == S_SCAN);
    assign w_accept = start && !busy;
    assign w_pos    = CW'(i_position);
    assign w_full   = (r_held == CW'(DEPTH));
    assign w_ins_pos = (w_pos > r_held) ? r_held : w_pos;

    // row of cells, each fed by its neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = i_value;
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end
        iss_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_ins_pos (w_ins_pos),
            .i_pos     (w_pos),
            .i_held    (r_held),
            .i_value   (i_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_entry   (w_entry[k]),
            .o_hit     (w_hit[k])
        );
    end

    // priority scan over latched match flags
    assign w_first = w_hit & (~w_hit + DEPTH'(1));
    always_comb begin
        w_idx  = '0;
        w_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_first[k]) begin
                w_idx  = w_idx | PW'(k);
                w_data = w_data | w_entry[k];
            end
        end
    end

    // command decode and result selection
    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_is_read = r_is_read;
        n_done    = 1'b0;
        n_status  = ST_OK;
        n_rd      = '0;
        n_fpos    = '0;
        w_ctrl    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b1;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctrl.ins = 1'b1;
                                n_held     = r_held + CW'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (r_held == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos >= r_held) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_ctrl.del = 1'b1;
                                n_held     = r_held - CW'(1);
                            end
                        end
                        CMD_READ: begin
                            if (w_pos >= r_held) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_ctrl.rd = 1'b1;
                                n_is_read = 1'b1;
                                n_done    = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        CMD_SEARCH: begin
                            w_ctrl.find = 1'b1;
                            n_is_read   = 1'b0;
                            n_done      = 1'b0;
                            n_state     = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_held = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_is_read) begin
                    n_rd = w_data;
                end else if (|w_hit) begin
                    n_fpos = FPOS_W'(w_idx);
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, count and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_held    <= '0;
            r_done    <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_held    <= n_held;
            r_done    <= n_done;
            r_is_read <= n_is_read;
        end
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_value     = r_rd;
    assign o_found_position = r_fpos;
    assign o_count          = CNT_W'(r_held);

    // checks
    `ISS_ASSERT_NEXT(a_scan_one_cycle, busy, !busy)
    `ISS_ASSERT_NEXT(a_search_scans, start && !busy && i_cmd == CMD_SEARCH, busy && !o_done)
    `ISS_ASSERT_NOW(a_scan_ends_done, !busy && $past(busy), o_done)
    `ISS_ASSERT_NOW(a_held_bound, 1'b1, r_held <= CW'(DEPTH))
    `ISS_ASSERT_NOW(a_miss_zero, o_done && o_status == ST_NOTFOUND,
        o_found_position == '0 && o_read_value == '0)

endmodule
